// ----- rtl/wsp_pkg.sv -----
// ----------------------------------------------------------------------------
// WAV stream parser package
// Phase, error code and result types shared by the parser, its header
// check and its output buffer.
// ----------------------------------------------------------------------------
package wsp_pkg;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_FMTSKIP,
    PH_CHUNKHDR,
    PH_CHUNKSKIP,
    PH_DATA,
    PH_WAIT
  } phase_t;

  typedef enum logic [3:0] {
    ERR_NOT_RIFF  = 4'd0,
    ERR_NOT_WAVE  = 4'd1,
    ERR_NO_FMT    = 4'd2,
    ERR_NOT_PCM   = 4'd3,
    ERR_NOT_MONO  = 4'd4,
    ERR_BYTE_RATE = 4'd5,
    ERR_ALIGN     = 4'd6,
    ERR_DEPTH     = 4'd7,
    ERR_NO_DATA   = 4'd8
  } err_t;

  localparam logic        KIND_SAMPLE = 1'b0;
  localparam logic        KIND_ERROR  = 1'b1;

  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [15:0] FMT_PCM    = 16'd1;
  localparam logic [15:0] CHAN_MONO  = 16'd1;
  localparam logic [15:0] DEPTH_16   = 16'd16;
  localparam logic [31:0] FMT_LEN_STD = 32'd16;

  localparam logic [31:0] HDR_LAST_IDX  = 32'd35;
  localparam logic [31:0] CHDR_LAST_IDX = 32'd7;
  localparam logic [31:0] CHDR_TAG_LEN  = 32'd4;

  typedef struct packed {
    logic [31:0] riff;
    logic [31:0] wave;
    logic [31:0] fmt;
    logic [31:0] fmt_len;
    logic [15:0] channels;
    logic [15:0] format;
    logic [31:0] rate;
    logic [31:0] avg_bps;
    logic [15:0] align;
    logic [7:0]  bits_lo;
    logic [31:0] prod_lo;
  } hdr_t;

  typedef struct packed {
    logic        valid;
    logic        kind;
    logic [15:0] sample;
    err_t        code;
    logic [31:0] rate;
  } res_t;

endpackage

// ----- rtl/wsp_hdr_check.sv -----
// ----------------------------------------------------------------------------
// WAV header check
// Checks the captured RIFF/fmt header against the final header byte and
// reports the first failing field.
// ----------------------------------------------------------------------------
module wsp_hdr_check
  import wsp_pkg::*;
(
  input  hdr_t       hdr,
  input  logic [7:0] last_byte,
  output logic       pass,
  output err_t       code
);

  logic [15:0] bits;
  logic [39:0] hi_prod;
  logic [31:0] prod;

  assign bits    = {last_byte, hdr.bits_lo};
  assign hi_prod = hdr.rate * {32'd0, last_byte};
  assign prod    = hdr.prod_lo + {hi_prod[23:0], 8'h00};

  always_comb begin
    pass = 1'b0;
    code = ERR_NOT_RIFF;
    if (hdr.riff != TAG_RIFF) begin
      code = ERR_NOT_RIFF;
    end else if (hdr.wave != TAG_WAVE) begin
      code = ERR_NOT_WAVE;
    end else if (hdr.fmt != TAG_FMT) begin
      code = ERR_NO_FMT;
    end else if (hdr.format != FMT_PCM) begin
      code = ERR_NOT_PCM;
    end else if (hdr.channels != CHAN_MONO) begin
      code = ERR_NOT_MONO;
    end else if (hdr.avg_bps != {3'b000, prod[31:3]}) begin
      code = ERR_BYTE_RATE;
    end else if (hdr.align != {3'b000, bits[15:3]}) begin
      code = ERR_ALIGN;
    end else if (bits != DEPTH_16) begin
      code = ERR_DEPTH;
    end else begin
      pass = 1'b1;
    end
  end

endmodule

// ----- rtl/wsp_parser.sv -----
// ----------------------------------------------------------------------------
// WAV byte parser
// Captures the header, walks the chunk list and pairs data bytes into
// samples; one accepted byte is handled per cycle.
// ----------------------------------------------------------------------------
module wsp_parser
  import wsp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       take,
  input  logic [7:0] data_byte,
  input  logic       last,
  output res_t       res
);

  localparam logic [3:0] W_RIFF  = 4'd0;
  localparam logic [3:0] W_WAVE  = 4'd2;
  localparam logic [3:0] W_FMT   = 4'd3;
  localparam logic [3:0] W_FLEN  = 4'd4;
  localparam logic [3:0] W_FINFO = 4'd5;
  localparam logic [3:0] W_RATE  = 4'd6;
  localparam logic [3:0] W_BRATE = 4'd7;
  localparam logic [3:0] W_BITS  = 4'd8;

  phase_t      phase_r, phase_nxt;
  logic [31:0] cnt_r, cnt_nxt;
  logic [31:0] tag_r, tag_nxt;
  logic [31:0] len_r, len_nxt;
  logic [7:0]  low_r, low_nxt;
  logic        half_r, half_nxt;
  hdr_t        hdr_r;

  logic        hdr_pass;
  err_t        hdr_code;
  logic [31:0] cnt_inc;
  logic [39:0] lo_prod;
  logic [4:0]  bsel;

  assign cnt_inc = cnt_r + 32'd1;
  assign lo_prod = hdr_r.rate * {32'd0, data_byte};
  assign bsel    = {cnt_r[1:0], 3'b000};

  wsp_hdr_check u_check (
    .hdr       (hdr_r),
    .last_byte (data_byte),
    .pass      (hdr_pass),
    .code      (hdr_code)
  );

  always_ff @(posedge clk) begin
    if (take && phase_r == PH_HEADER) begin
      case (cnt_r[5:2])
        W_RIFF:  hdr_r.riff[bsel +: 8] <= data_byte;
        W_WAVE:  hdr_r.wave[bsel +: 8] <= data_byte;
        W_FMT:   hdr_r.fmt[bsel +: 8] <= data_byte;
        W_FLEN:  hdr_r.fmt_len[bsel +: 8] <= data_byte;
        W_FINFO: begin
          if (cnt_r[1]) begin
            hdr_r.channels[bsel[3:0] +: 8] <= data_byte;
          end else begin
            hdr_r.format[bsel[3:0] +: 8] <= data_byte;
          end
        end
        W_RATE:  hdr_r.rate[bsel +: 8] <= data_byte;
        W_BRATE: hdr_r.avg_bps[bsel +: 8] <= data_byte;
        W_BITS: begin
          if (!cnt_r[1]) begin
            hdr_r.align[bsel[3:0] +: 8] <= data_byte;
          end else if (!cnt_r[0]) begin
            hdr_r.bits_lo <= data_byte;
            hdr_r.prod_lo <= lo_prod[31:0];
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      cnt_r   <= '0;
      tag_r   <= '0;
      len_r   <= '0;
      low_r   <= '0;
      half_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      tag_r   <= tag_nxt;
      len_r   <= len_nxt;
      low_r   <= low_nxt;
      half_r  <= half_nxt;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    tag_nxt   = tag_r;
    len_nxt   = len_r;
    low_nxt   = low_r;
    half_nxt  = half_r;
    if (take) begin
      case (phase_r)
        PH_HEADER: begin
          cnt_nxt = cnt_inc;
          if (cnt_r == HDR_LAST_IDX) begin
            if (!hdr_pass) begin
              phase_nxt = PH_WAIT;
            end else begin
              cnt_nxt   = '0;
              len_nxt   = (hdr_r.fmt_len > FMT_LEN_STD) ?
                          hdr_r.fmt_len - FMT_LEN_STD : 32'd0;
              phase_nxt = (len_nxt != 32'd0) ? PH_FMTSKIP : PH_CHUNKHDR;
            end
          end
        end
        PH_FMTSKIP, PH_CHUNKSKIP: begin
          cnt_nxt = cnt_inc;
          if (cnt_inc == len_r) begin
            cnt_nxt   = '0;
            phase_nxt = PH_CHUNKHDR;
          end
        end
        PH_CHUNKHDR: begin
          if (cnt_r < CHDR_TAG_LEN) begin
            tag_nxt = {data_byte, tag_r[31:8]};
          end else begin
            len_nxt = {data_byte, len_r[31:8]};
          end
          cnt_nxt = cnt_inc;
          if (cnt_r == CHDR_LAST_IDX) begin
            cnt_nxt = '0;
            if (tag_r == TAG_DATA) begin
              phase_nxt = PH_DATA;
            end else begin
              phase_nxt = (len_nxt != 32'd0) ? PH_CHUNKSKIP : PH_CHUNKHDR;
            end
          end
        end
        PH_DATA: begin
          if (!half_r) begin
            low_nxt = data_byte;
          end
          half_nxt = !half_r;
        end
        default: ;
      endcase
      if (last) begin
        phase_nxt = PH_HEADER;
        cnt_nxt   = '0;
        tag_nxt   = '0;
        len_nxt   = '0;
        low_nxt   = '0;
        half_nxt  = 1'b0;
      end
    end
  end

  always_comb begin
    res = '0;
    res.code = ERR_NOT_RIFF;
    if (take) begin
      case (phase_r)
        PH_HEADER: begin
          if (cnt_r != HDR_LAST_IDX) begin
            if (last) begin
              res.valid = 1'b1;
              res.kind  = KIND_ERROR;
              res.code  = ERR_NO_DATA;
            end
          end else if (!hdr_pass || last) begin
            res.valid = 1'b1;
            res.kind  = KIND_ERROR;
            res.code  = hdr_pass ? ERR_NO_DATA : hdr_code;
            res.rate  = hdr_r.rate;
          end
        end
        PH_FMTSKIP, PH_CHUNKSKIP: begin
          if (last) begin
            res.valid = 1'b1;
            res.kind  = KIND_ERROR;
            res.code  = ERR_NO_DATA;
            res.rate  = hdr_r.rate;
          end
        end
        PH_CHUNKHDR: begin
          if (last && (cnt_r != CHDR_LAST_IDX || tag_r != TAG_DATA)) begin
            res.valid = 1'b1;
            res.kind  = KIND_ERROR;
            res.code  = ERR_NO_DATA;
            res.rate  = hdr_r.rate;
          end
        end
        PH_DATA: begin
          if (half_r) begin
            res.valid  = 1'b1;
            res.kind   = KIND_SAMPLE;
            res.sample = {data_byte, low_r};
            res.rate   = hdr_r.rate;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/wsp_out_buf.sv -----
// ----------------------------------------------------------------------------
// WAV parser output buffer
// Two-entry result buffer; stalls the input only when both entries hold
// results.
// ----------------------------------------------------------------------------
module wsp_out_buf
  import wsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  res_t        res,
  input  logic        out_stall,
  output logic        out_valid,
  output logic        out_kind,
  output logic [15:0] out_sample,
  output logic [3:0]  out_error_code,
  output logic [31:0] out_sample_rate,
  output logic        full
);

  res_t head_r, head_nxt;
  res_t spare_r, spare_nxt;
  logic head_v_r, head_v_nxt;
  logic spare_v_r, spare_v_nxt;
  logic pop;

  assign pop = head_v_r && !out_stall;

  always_comb begin
    head_nxt    = head_r;
    spare_nxt   = spare_r;
    head_v_nxt  = head_v_r;
    spare_v_nxt = spare_v_r;
    if (pop) begin
      if (spare_v_r) begin
        head_nxt    = spare_r;
        spare_nxt   = res;
        spare_v_nxt = res.valid;
      end else begin
        head_nxt   = res;
        head_v_nxt = res.valid;
      end
    end else if (res.valid) begin
      if (!head_v_r) begin
        head_nxt   = res;
        head_v_nxt = 1'b1;
      end else begin
        spare_nxt   = res;
        spare_v_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_v_r  <= 1'b0;
      spare_v_r <= 1'b0;
    end else begin
      head_v_r  <= head_v_nxt;
      spare_v_r <= spare_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r  <= head_nxt;
    spare_r <= spare_nxt;
  end

  assign out_valid       = head_v_r;
  assign out_kind        = head_r.kind;
  assign out_sample      = head_r.sample;
  assign out_error_code  = head_r.code;
  assign out_sample_rate = head_r.rate;
  assign full            = spare_v_r;

endmodule

// ----- rtl/wav_stream_parser.sv -----
// ----------------------------------------------------------------------------
// WAV stream parser
// Byte-serial RIFF/WAVE parser for 16-bit mono PCM: header check, chunk
// skipping and sample assembly, with errors reported as results.
// ----------------------------------------------------------------------------
// Output: each result is registered in the output buffer before it shows on out_*.
// Throughput: one byte per cycle; the two-entry output buffer stalls input
// only after two results wait on a stalled output.
// Reset: synchronous rst_n clears phase, counters and the buffer; the next
// byte starts a new file. Header capture registers hold until overwritten.
module wav_stream_parser
  import wsp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_data_byte,
  input  logic               in_last,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_kind,
  output logic signed [15:0] out_sample,
  output logic [3:0]         out_error_code,
  output logic [31:0]        out_sample_rate
);

  res_t        res;
  logic        take;
  logic        full;
  logic [15:0] sample_bits;

  assign take       = in_valid && !in_stall;
  assign in_stall   = full;
  assign out_sample = sample_bits;

  wsp_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .data_byte (in_data_byte),
    .last      (in_last),
    .res       (res)
  );

  wsp_out_buf u_out_buf (
    .clk             (clk),
    .rst_n           (rst_n),
    .res             (res),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_kind        (out_kind),
    .out_sample      (sample_bits),
    .out_error_code  (out_error_code),
    .out_sample_rate (out_sample_rate),
    .full            (full)
  );

  a_stall_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with empty output");

  a_result_on_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> (in_valid && !in_stall))
    else $error("result without input transfer");

  a_error_zero_sample: assert property (@(posedge clk) disable iff (!rst_n)
    (res.valid && res.kind == KIND_ERROR) |-> (res.sample == 16'd0))
    else $error("error result carries sample bits");

  a_empty_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_valid)
    else $error("output valid right after reset");

endmodule
